>>> rtl/xos_pkg.sv
package xos_pkg;

  typedef enum logic [1:0] {
    OP_RAW   = 2'd0,
    OP_FRAC  = 2'd1,
    OP_BOUND = 2'd2,
    OP_SEED  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAW,
    ST_MUL,
    ST_CHECK,
    ST_MOD,
    ST_SMIX,
    ST_SMUL,
    ST_OUT
  } state_e;

  localparam logic [63:0] SmGamma = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SmMul1  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] SmMul2  = 64'h94D049BB133111EB;

  // Request to the shared multiplier.
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

endpackage

>>> rtl/xos_mul.sv
// 64x64 -> 128 multiplier, one 32x32 partial product per cycle.
module xos_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xos_pkg::mul_req_t req_i,
  output xos_pkg::mul_rsp_t rsp_o
);

  logic [63:0]  a_q, b_q;
  logic [127:0] acc_q;
  logic [2:0]   cnt_q;
  logic         busy_q, done_q;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  always_comb begin
    pa    = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    pb    = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    pp    = {32'd0, pa} * {32'd0, pb};
    pp_sh = {64'd0, pp} << (7'(cnt_q[1]) * 7'd32 + 7'(cnt_q[0]) * 7'd32);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

>>> rtl/xos_div.sv
// Restoring remainder unit: one quotient bit per cycle.
module xos_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] rem_o
);

  logic [63:0] num_q, den_q, rem_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] trial;
  logic [64:0] diff;

  always_comb begin
    trial = {rem_q, num_q[63]};
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[62:0], 1'b0};
      rem_q <= diff[64] ? trial[63:0] : diff[63:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/xoshiro256ss_generator.sv
// Channel | Dir | Signals                          | Accepted when
// request | in  | opcode_i, bound_i, seed_i        | in_valid_i && in_ready_o
// result  | out | value_o                          | out_valid_o && out_ready_i
//
// Raw and fraction draws raise out_valid_o once the word is taken and the x5 and x9
// scrambler products have each passed through the shared multiplier (a start, then
// one 32x32 partial product a cycle). A bounded draw adds a third product and a
// check state, plus a bit-serial remainder when the low word falls under the bound;
// every rejection costs another draw. A reseed runs four mixer rounds of two
// multiplies each before in_ready_o returns.
// Reset loads state word 0 with one and clears the rest; the block holds the
// result in value_o until taken and accepts nothing until then.
module xoshiro256ss_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] bound_i,
  input  logic [63:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_o
);

  xos_pkg::state_e state_q, state_d;
  xos_pkg::op_e    op_q;
  xos_pkg::mul_req_t mreq;
  xos_pkg::mul_rsp_t mrsp;

  logic [63:0] s0_q, s1_q, s2_q, s3_q;
  logic [63:0] bound_q, acc_q, z_q, limit_q, value_q, w0_q, w1_q, w2_q;
  logic [1:0]  step_q;   // scrambler: 0 = x5, 1 = x9, 2 = bound; mixer: 0..1 sub-step
  logic [1:0]  word_q;   // which seed word the mixer is producing
  logic        lim_ok_q; // rejection limit computed for this draw
  logic        div_start, div_done;
  logic [63:0] div_rem;
  logic [63:0] rot7, z_next;
  logic [63:0] n2, n3, n1, n0;

  // State advance (all xor/shift, combinational).
  always_comb begin
    n2 = s2_q ^ s0_q;
    n3 = s3_q ^ s1_q;
    n1 = s1_q ^ n2;
    n0 = s0_q ^ n3;
    n2 = n2 ^ (s1_q << 17);
    n3 = {n3[18:0], n3[63:19]};
    rot7 = {mrsp.prod[56:0], mrsp.prod[63:57]};
  end

  xos_mul u_mul (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));

  xos_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .num_i  (64'd0 - bound_q),
    .den_i  (bound_q),
    .done_o (div_done),
    .rem_o  (div_rem)
  );

  // Mixer xor-shift applied to the last product, by sub-step.
  always_comb begin
    case (step_q)
      2'd0:    z_next = mrsp.prod[63:0] ^ (mrsp.prod[63:0] >> 27);
      default: z_next = mrsp.prod[63:0] ^ (mrsp.prod[63:0] >> 31);
    endcase
  end

  always_comb begin
    state_d   = state_q;
    mreq      = '0;
    div_start = 1'b0;
    case (state_q)
      xos_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (xos_pkg::op_e'(opcode_i) == xos_pkg::OP_SEED) begin
            state_d = xos_pkg::ST_SMIX;
          end else begin
            state_d = xos_pkg::ST_DRAW;
          end
        end
      end
      xos_pkg::ST_DRAW: begin
        // multiply s1 by 5; result scrambled in ST_MUL
        mreq.start = 1'b1;
        mreq.a     = s1_q;
        mreq.b     = 64'd5;
        state_d    = xos_pkg::ST_MUL;
      end
      xos_pkg::ST_MUL: begin
        if (mrsp.done) begin
          if (step_q == 2'd0) begin
            mreq.start = 1'b1;
            mreq.a     = rot7;
            mreq.b     = 64'd9;
          end else if (op_q == xos_pkg::OP_BOUND && step_q == 2'd1) begin
            mreq.start = 1'b1;
            mreq.a     = mrsp.prod[63:0];
            mreq.b     = bound_q;
          end else if (op_q == xos_pkg::OP_BOUND) begin
            state_d = xos_pkg::ST_CHECK;
          end else begin
            state_d = xos_pkg::ST_OUT;
          end
        end
      end
      xos_pkg::ST_CHECK: begin
        if (bound_q == '0 || z_q >= bound_q) begin
          state_d = xos_pkg::ST_OUT;
        end else if (!lim_ok_q) begin
          div_start = 1'b1;
          state_d   = xos_pkg::ST_MOD;
        end else if (z_q < limit_q) begin
          state_d = xos_pkg::ST_DRAW;
        end else begin
          state_d = xos_pkg::ST_OUT;
        end
      end
      xos_pkg::ST_MOD: begin
        if (div_done) begin
          state_d = xos_pkg::ST_CHECK;
        end
      end
      xos_pkg::ST_SMIX: begin
        mreq.start = 1'b1;
        mreq.a     = z_q ^ (z_q >> 30);
        mreq.b     = xos_pkg::SmMul1;
        state_d    = xos_pkg::ST_SMUL;
      end
      xos_pkg::ST_SMUL: begin
        if (mrsp.done) begin
          if (step_q == 2'd0) begin
            mreq.start = 1'b1;
            mreq.a     = z_next;
            mreq.b     = xos_pkg::SmMul2;
          end else if (word_q != 2'd3) begin
            state_d = xos_pkg::ST_SMIX;
          end else begin
            state_d = xos_pkg::ST_IDLE;
          end
        end
      end
      xos_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = xos_pkg::ST_IDLE;
        end
      end
      default: state_d = xos_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xos_pkg::ST_IDLE;
      s0_q    <= 64'd1;
      s1_q    <= '0;
      s2_q    <= '0;
      s3_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == xos_pkg::ST_DRAW) begin
        s0_q <= n0;
        s1_q <= n1;
        s2_q <= n2;
        s3_q <= n3;
      end
      if (state_q == xos_pkg::ST_SMUL && mrsp.done && step_q == 2'd1 && word_q == 2'd3) begin
        // commit seed words; force word 0 to one if all came out zero
        s0_q <= ((w0_q | w1_q | w2_q | z_next) == '0) ? 64'd1 : w0_q;
        s1_q <= w1_q;
        s2_q <= w2_q;
        s3_q <= z_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      xos_pkg::ST_IDLE: begin
        op_q     <= xos_pkg::op_e'(opcode_i);
        bound_q  <= bound_i;
        acc_q    <= seed_i + xos_pkg::SmGamma;
        z_q      <= seed_i + xos_pkg::SmGamma;
        word_q   <= '0;
        step_q   <= '0;
        lim_ok_q <= 1'b0;
      end
      xos_pkg::ST_DRAW: step_q <= '0;
      xos_pkg::ST_MUL: begin
        if (mrsp.done) begin
          step_q <= step_q + 2'd1;
          if (step_q == 2'd1) begin
            value_q <= (op_q == xos_pkg::OP_FRAC) ? (mrsp.prod[63:0] >> 11)
                                                  : mrsp.prod[63:0];
          end
          if (step_q == 2'd2) begin
            value_q <= mrsp.prod[127:64];
            z_q     <= mrsp.prod[63:0];
          end
        end
      end
      xos_pkg::ST_MOD: begin
        if (div_done) begin
          limit_q  <= div_rem;
          lim_ok_q <= 1'b1;
        end
      end
      xos_pkg::ST_SMIX: step_q <= '0;
      xos_pkg::ST_SMUL: begin
        if (mrsp.done) begin
          step_q <= step_q + 2'd1;
          if (step_q == 2'd1) begin
            case (word_q)
              2'd0:    w0_q <= z_next;
              2'd1:    w1_q <= z_next;
              default: w2_q <= z_next;
            endcase
            word_q <= word_q + 2'd1;
            acc_q  <= acc_q + xos_pkg::SmGamma;
            z_q    <= acc_q + xos_pkg::SmGamma;
          end
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == xos_pkg::ST_IDLE);
  assign out_valid_o = (state_q == xos_pkg::ST_OUT);
  assign value_o     = value_q;

endmodule

>>> rtl/xos_checker.sv
module xos_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] value_o
);

  a_no_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while result pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("ready right after accept");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(value_o)))
    else $error("result dropped or changed");

  a_free_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> (in_ready_o && !out_valid_o))
    else $error("not idle after result taken");

endmodule

bind xoshiro256ss_generator xos_checker u_xos_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .value_o
);

>>> tb/sv/tb_xoshiro256ss_generator.sv
`timescale 1ns / 100ps

module tb_xoshiro256ss_generator;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned NumRandom  = 830;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  opcode_i;
  logic [63:0] bound_i;
  logic [63:0] seed_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] value_o;

  xoshiro256ss_generator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .bound_i     (bound_i),
    .seed_i      (seed_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o)
  );

  // Generator state mirrored on every accepted request word.
  logic [63:0] gen_q [4];
  logic [63:0] pending_values [$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit          stim_done;
  bit          long_stall;

  // Directed stimulus: opcode, bound, seed, and a known value where one is obvious.
  typedef struct {
    xos_pkg::op_e op;
    logic [63:0]  bound;
    logic [63:0]  seed;
    bit           has_known;
    logic [63:0]  known;
  } req_row_t;

  req_row_t directed_rows [] = '{
    // After reset only word 0 is set, so the first raw draw is zero.
    '{xos_pkg::OP_RAW,   64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0},
    '{xos_pkg::OP_RAW,   64'h0, 64'h0, 1'b0, 64'h0},
    '{xos_pkg::OP_FRAC,  64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 64'h0},
    // Zero bound always yields zero.
    '{xos_pkg::OP_BOUND, 64'h0, 64'h0, 1'b1, 64'h0},
    // Bound of one always yields zero.
    '{xos_pkg::OP_BOUND, 64'h1, 64'h0, 1'b1, 64'h0},
    '{xos_pkg::OP_BOUND, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 64'h0},
    '{xos_pkg::OP_BOUND, 64'h8000_0000_0000_0001, 64'h0, 1'b0, 64'h0},
    '{xos_pkg::OP_BOUND, 64'h3, 64'h0, 1'b0, 64'h0},
    '{xos_pkg::OP_SEED,  64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 64'h0},
    '{xos_pkg::OP_RAW,   64'h0, 64'h0, 1'b0, 64'h0},
    '{xos_pkg::OP_SEED,  64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
    '{xos_pkg::OP_FRAC,  64'h0, 64'h0, 1'b0, 64'h0},
    // Seed that lands the accumulator on zero in the first round.
    '{xos_pkg::OP_SEED,  64'h0, 64'h61C8_8646_80B5_83EB, 1'b0, 64'h0},
    '{xos_pkg::OP_RAW,   64'h0, 64'h0, 1'b0, 64'h0},
    '{xos_pkg::OP_BOUND, 64'h7, 64'h0, 1'b0, 64'h0},
    '{xos_pkg::OP_BOUND, 64'hAAAA_AAAA_AAAA_AAAB, 64'h0, 1'b0, 64'h0},
    '{xos_pkg::OP_SEED,  64'h0, 64'h1234_5678_9ABC_DEF0, 1'b0, 64'h0},
    '{xos_pkg::OP_FRAC,  64'h0, 64'h0, 1'b0, 64'h0},
    '{xos_pkg::OP_RAW,   64'h0, 64'h0, 1'b0, 64'h0}
  };

  function automatic logic [63:0] rotl64(logic [63:0] v, int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

  // Step the mirrored state once and return the scrambled word.
  function automatic logic [63:0] next_word();
    logic [63:0] result;
    logic [63:0] t;
    result = rotl64(gen_q[1] * 64'd5, 7) * 64'd9;
    t = gen_q[1] << 17;
    gen_q[2] ^= gen_q[0];
    gen_q[3] ^= gen_q[1];
    gen_q[1] ^= gen_q[2];
    gen_q[0] ^= gen_q[3];
    gen_q[2] ^= t;
    gen_q[3] = rotl64(gen_q[3], 45);
    return result;
  endfunction

  function automatic logic [63:0] draw_below(logic [63:0] bound);
    logic [127:0] prod;
    logic [63:0]  threshold;
    prod = 128'(next_word()) * 128'(bound);
    if (bound != 64'h0 && prod[63:0] < bound) begin
      threshold = (64'h0 - bound) % bound;
      while (prod[63:0] < threshold) begin
        prod = 128'(next_word()) * 128'(bound);
      end
    end
    return prod[127:64];
  endfunction

  function automatic void load_seed(logic [63:0] seed);
    logic [63:0] acc;
    logic [63:0] z;
    acc = seed;
    for (int i = 0; i < 4; i++) begin
      acc += xos_pkg::SmGamma;
      z = acc;
      z = (z ^ (z >> 30)) * xos_pkg::SmMul1;
      z = (z ^ (z >> 27)) * xos_pkg::SmMul2;
      gen_q[i] = z ^ (z >> 31);
    end
    if ((gen_q[0] | gen_q[1] | gen_q[2] | gen_q[3]) == 64'h0) begin
      gen_q[0] = 64'h1;
    end
  endfunction

  // Predict the accepted word; push the expected value if one is produced.
  function automatic void predict_word(xos_pkg::op_e op, logic [63:0] bound,
                                       logic [63:0] seed);
    case (op)
      xos_pkg::OP_RAW:   pending_values.push_back(next_word());
      xos_pkg::OP_FRAC:  pending_values.push_back(next_word() >> 11);
      xos_pkg::OP_BOUND: pending_values.push_back(draw_below(bound));
      default:           load_seed(seed);
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hold valid and payload until the handshake completes.
  task automatic send_word(xos_pkg::op_e op, logic [63:0] bound, logic [63:0] seed);
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    bound_i    <= bound;
    seed_i     <= seed;
    do @(posedge clk_i); while (!in_ready_o);
    predict_word(op, bound, seed);
  endtask

  task automatic random_word();
    logic [63:0]  bound;
    logic [63:0]  seed;
    xos_pkg::op_e op;
    int unsigned  pick;
    pick = $urandom_range(0, 99);
    op = (pick < 30) ? xos_pkg::OP_RAW : (pick < 50) ? xos_pkg::OP_FRAC :
         (pick < 90) ? xos_pkg::OP_BOUND : xos_pkg::OP_SEED;
    bound = {$urandom(), $urandom()};
    // Favor small and near-power-of-two bounds where rejection bites.
    case ($urandom_range(0, 3))
      0: bound = bound >> $urandom_range(0, 63);
      1: bound = (64'h1 << $urandom_range(0, 63)) + 64'($urandom_range(0, 2));
      default: ;
    endcase
    seed = {$urandom(), $urandom()};
    send_word(op, bound, seed);
  endtask

  // Sender: directed rows, then random bursts separated by gaps.
  initial begin
    int unsigned burst;
    int unsigned sent;
    in_valid_i <= 1'b0;
    opcode_i   <= xos_pkg::OP_RAW;
    bound_i    <= '0;
    seed_i     <= '0;
    stim_done  = 1'b0;
    sent = 0;
    gen_q[0] = 64'h1;
    gen_q[1] = '0;
    gen_q[2] = '0;
    gen_q[3] = '0;
    @(posedge rst_ni);
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].op, directed_rows[i].bound, directed_rows[i].seed);
      if (directed_rows[i].has_known
          && pending_values[$] !== directed_rows[i].known) begin
        $display("%0t: row %0d predictor expected %h, table says %h", $time, i,
                 pending_values[$], directed_rows[i].known);
        error_count++;
      end
    end
    while (sent < NumRandom) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < NumRandom; b++) begin
        random_word();
        sent++;
      end
      // Some bursts run back to back.
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: stall on its own pattern, with one long hold-off to back up the input.
  initial begin
    int unsigned mode;
    out_ready_i <= 1'b0;
    long_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (cycle_count == 3000 && !long_stall) begin
        long_stall = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      mode = (cycle_count / 500) % 3;
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Compare each taken result with the oldest expectation.
  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, value_o);
        error_count++;
      end else begin
        want = pending_values.pop_front();
        if (value_o !== want) begin
          $display("%0t: value mismatch, expected %h, actual %h", $time, want, value_o);
          error_count++;
        end
      end
    end
  end

  // Count cycles and drop the run if it never drains.
  initial begin
    error_count = 0;
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (pending_values.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_count == 0 && pending_values.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
